// ===== hdl/bis_pkg.sv =====
// shared constants, operation and status codes, and cell control type for the search stack
package bis_pkg;

    // defaults for the top level parameters
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // capacity register value after reset, before saturation to the depth
    localparam int CAP_RESET = 64;

    // field widths fixed by the interface
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic [KIND_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [KIND_W-1:0] OP_POP    = 3'd1;
    localparam logic [KIND_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [KIND_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [KIND_W-1:0] OP_SEARCH = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

    // per-cycle commands broadcast to every cell of the chain
    typedef struct packed {
        logic shift_dn;   // push: every word moves one cell away from the top
        logic shift_up;   // pop: every word moves one cell toward the top
        logic load_hit;   // search start: each cell compares its word with the key
        logic shift_hit;  // search scan: match flags move one cell toward the top
    } t_cell_ctl;

endpackage

// ===== hdl/bis_cell.sv =====
// one stack cell: a stored word and a match flag, both shifting between neighbors
module bis_cell #(
    parameter int DATA_WIDTH = bis_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  bis_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic [DATA_WIDTH-1:0] i_word_up,
    input  logic [DATA_WIDTH-1:0] i_word_dn,
    input  logic                  i_hit_dn,
    output logic [DATA_WIDTH-1:0] o_word,
    output logic                  o_hit
);
    import bis_pkg::*;

    logic [DATA_WIDTH-1:0] r_word;
    logic                  r_hit;

    // word moves with push and pop, flag is loaded on compare and moves during scan
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_dn) begin
            r_word <= i_word_up;
        end else if (i_ctl.shift_up) begin
            r_word <= i_word_dn;
        end

        if (i_ctl.load_hit) begin
            r_hit <= (r_word == i_key);
        end else if (i_ctl.shift_hit) begin
            r_hit <= i_hit_dn;
        end
    end

    assign o_word = r_word;
    assign o_hit  = r_hit;

endmodule

// ===== hdl/bounded_int_stack_with_search.sv =====
// top level of the bounded stack with search: control, count, capacity and result registers
// The stack is a chain of DEPTH cells with the top word always in the first cell, so push,
// pop, peek and clear finish in the cycle the word is accepted and register their result. A
// search latches one compare flag in every cell in the accept cycle, then scans from the
// top until the first match, or through all count entries for not found, since the flags
// shift one cell per cycle toward the top, where a single check looks at them. A finished
// result waits in a holding register while the output is stalled, and a new word is
// accepted while that holding register is empty and no search is scanning. Capacity
// writes take effect at the next edge; values above DEPTH act as DEPTH. No clearing pass
// is needed after reset.
module bounded_int_stack_with_search #(
    parameter int DEPTH      = bis_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bis_pkg::DATA_WIDTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // capacity register
    input  logic                          i_cfg_wen,
    input  logic [CW-1:0]                 i_cfg_wdata,
    // operation channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bis_pkg::KIND_W-1:0]    i_kind,
    input  logic signed [DATA_WIDTH-1:0]  i_value,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bis_pkg::STATUS_W-1:0]  o_status,
    output logic signed [DATA_WIDTH-1:0]  o_data,
    output logic [CW-1:0]                 o_count,
    output logic                          o_empty_flag,
    output logic                          o_full_flag
);
    import bis_pkg::*;

    localparam int CAP_INIT = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [DATA_WIDTH-1:0] data;
        logic [CW-1:0]         count;
        logic                  empty;
        logic                  full;
    } t_res;

    logic                  r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_j, n_j;
    logic [CW-1:0]         r_cap;
    logic [CW-1:0]         w_cap;
    logic                  r_out_valid;
    logic                  r_pend_valid;
    t_res                  r_out;
    t_res                  r_pend;
    t_res                  w_res;
    logic                  w_res_valid;
    logic                  w_accept;
    logic                  w_out_free;
    t_cell_ctl             w_ctl;
    logic [DATA_WIDTH-1:0] w_word [DEPTH];
    logic                  w_hit  [DEPTH];

    // capacity saturated to the depth
    assign w_cap = (r_cap > CW'(DEPTH)) ? CW'(DEPTH) : r_cap;

    // handshakes
    assign o_in_stall = (r_state == S_SCAN) || r_pend_valid;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // cell chain, first cell holds the top of the stack
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_up;
        logic [DATA_WIDTH-1:0] w_dn;
        logic                  w_hdn;

        if (g == 0) begin : g_first
            assign w_up = i_value;
        end else begin : g_mid
            assign w_up = w_word[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_dn  = '0;
            assign w_hdn = 1'b0;
        end else begin : g_inner
            assign w_dn  = w_word[g+1];
            assign w_hdn = w_hit[g+1];
        end

        bis_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_key     (i_value),
            .i_word_up (w_up),
            .i_word_dn (w_dn),
            .i_hit_dn  (w_hdn),
            .o_word    (w_word[g]),
            .o_hit     (w_hit[g])
        );
    end

    // operation decode and search scan
    always_comb begin
        w_ctl        = '0;
        n_state      = r_state;
        n_count      = r_count;
        n_j          = r_j;
        w_res_valid  = 1'b0;
        w_res.status = STAT_OK;
        w_res.data   = '0;

        if (r_state == S_SCAN) begin
            if (r_j == r_count) begin
                w_res_valid  = 1'b1;
                w_res.status = STAT_NOTFOUND;
                n_state      = S_IDLE;
            end else if (w_hit[0]) begin
                // flag at the top belongs to the entry j places below the top
                w_res_valid = 1'b1;
                w_res.data  = DATA_WIDTH'(CW'(r_count - r_j - CW'(1)));
                n_state     = S_IDLE;
            end else begin
                w_ctl.shift_hit = 1'b1;
                n_j             = r_j + CW'(1);
            end
        end else if (w_accept) begin
            unique case (i_kind)
                OP_PUSH: begin
                    w_res_valid = 1'b1;
                    if (r_count >= w_cap) begin
                        w_res.status = STAT_FULL;
                    end else begin
                        w_ctl.shift_dn = 1'b1;
                        n_count        = r_count + CW'(1);
                    end
                end
                OP_POP: begin
                    w_res_valid = 1'b1;
                    if (r_count == '0) begin
                        w_res.status = STAT_EMPTY;
                    end else begin
                        w_ctl.shift_up = 1'b1;
                        n_count        = r_count - CW'(1);
                        w_res.data     = w_word[0];
                    end
                end
                OP_PEEK: begin
                    w_res_valid = 1'b1;
                    if (r_count == '0) begin
                        w_res.status = STAT_EMPTY;
                    end else begin
                        w_res.data = w_word[0];
                    end
                end
                OP_CLEAR: begin
                    w_res_valid = 1'b1;
                    n_count     = '0;
                end
                OP_SEARCH: begin
                    w_ctl.load_hit = 1'b1;
                    n_state        = S_SCAN;
                    n_j            = '0;
                end
                default: begin
                    w_res_valid = 1'b1;
                end
            endcase
        end

        w_res.count = n_count;
        w_res.empty = (n_count == '0);
        w_res.full  = (n_count >= w_cap);
    end

    // control state, capacity, output and holding registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_j          <= '0;
            r_cap        <= CW'(CAP_INIT);
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_j     <= n_j;
            if (i_cfg_wen) begin
                r_cap <= i_cfg_wdata;
            end

            if (w_out_free) begin
                if (r_pend_valid) begin
                    r_out_valid  <= 1'b1;
                    r_out        <= r_pend;
                    r_pend_valid <= w_res_valid;
                    r_pend       <= w_res;
                end else begin
                    r_out_valid <= w_res_valid;
                    r_out       <= w_res;
                end
            end else if (!r_pend_valid) begin
                r_pend_valid <= w_res_valid;
                r_pend       <= w_res;
            end
        end
    end

    // result ports
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_data       = r_out.data;
    assign o_count      = r_out.count;
    assign o_empty_flag = r_out.empty;
    assign o_full_flag  = r_out.full;

endmodule
